>>> rtl/cdq_pkg.sv
// Package for the circular deque core: sizes, command and status codes,
// and the control struct passed from controller to datapath. No dependencies.
package cdq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_POS   = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the incoming command
    logic exec;   // perform the store access and pointer update
  } ctl_t;

endpackage

>>> rtl/circular_double_ended_queue_core.sv
// Top level of the circular deque core: controller plus datapath.
// Depends on cdq_pkg, cdq_ctrl and cdq_dpath.
//
//  channel   ports                                      transfer when
//  input     start, busy, in_command/value/position     start && !busy
//  result    out_strobe, out_data/status/occupancy      out_strobe
//
// Each command makes its store access, whose read port is registered, in the
// access state, then puts the result on the ports in the result state. busy is high
// only in the access cycle, so a new command is taken while a result shows.
// Reset (synchronous, rst_n low) empties the queue; store contents are
// left as they are. The receiver cannot stall: a result stands one cycle.
module circular_double_ended_queue_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [cdq_pkg::CMD_W-1:0]   in_command,
  input  logic [cdq_pkg::VALUE_W-1:0] in_value,
  input  logic [cdq_pkg::POS_W-1:0]   in_position,
  output logic                        out_strobe,
  output logic [cdq_pkg::DATA_W-1:0]  out_data,
  output logic [cdq_pkg::STAT_W-1:0]  out_status,
  output logic [cdq_pkg::OCC_W-1:0]   out_occupancy
);
  import cdq_pkg::*;

  ctl_t ctl;

  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .ctl        (ctl)
  );

  cdq_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_command    (in_command),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

endmodule

>>> rtl/cdq_ctrl.sv
// Controller for the circular deque core: sequences capture, store access
// and result strobe. Depends on cdq_pkg.
module cdq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_strobe,
  output cdq_pkg::ctl_t ctl
);
  import cdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_RESULT
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   strobe_r;
  logic   accept;

  assign accept     = start && !busy_r;
  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign ctl.load   = accept;
  assign ctl.exec   = (state_r == S_ACCESS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          strobe_r <= 1'b0;
          if (accept) begin
            state_r <= S_ACCESS;
            busy_r  <= 1'b1;
          end
        end
        S_ACCESS: begin
          state_r  <= S_RESULT;
          busy_r   <= 1'b0;
          strobe_r <= 1'b1;
        end
        S_RESULT: begin
          // next command may be taken while this result is shown
          strobe_r <= 1'b0;
          if (accept) begin
            state_r <= S_ACCESS;
            busy_r  <= 1'b1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r  <= S_IDLE;
          busy_r   <= 1'b0;
          strobe_r <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> busy_r)
    else $error("accepted transfer did not raise busy");
  a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> (strobe_r && !busy_r))
    else $error("store access not followed by result strobe");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

>>> rtl/cdq_dpath.sv
// Datapath for the circular deque core: command registers, head/tail/count,
// element store and result registers. Depends on cdq_pkg.
module cdq_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdq_pkg::ctl_t               ctl,
  input  logic [cdq_pkg::CMD_W-1:0]   in_command,
  input  logic [cdq_pkg::VALUE_W-1:0] in_value,
  input  logic [cdq_pkg::POS_W-1:0]   in_position,
  output logic [cdq_pkg::DATA_W-1:0]  out_data,
  output logic [cdq_pkg::STAT_W-1:0]  out_status,
  output logic [cdq_pkg::OCC_W-1:0]   out_occupancy
);
  import cdq_pkg::*;

  localparam int SUM_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [CMD_W-1:0]      cmd_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [POS_W-1:0]      pos_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [DATA_WIDTH-1:0] rd_q;
  logic                  rd_ok_r;
  logic [STAT_W-1:0]     status_r;
  logic [OCC_W-1:0]      occ_r;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  stat_t            stat;
  logic             full, empty;
  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic [SUM_W-1:0] pos_sum, pos_wrap;
  logic             pos_bad;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign head_inc = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IDX_LAST : head_r - 1'b1;
  assign tail_inc = (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? IDX_LAST : tail_r - 1'b1;

  // a valid position lies below count, so the sum stays under twice the depth
  assign pos_sum  = SUM_W'(head_r) + SUM_W'(pos_r);
  assign pos_wrap = (pos_sum >= SUM_DEPTH) ? pos_sum - SUM_DEPTH : pos_sum;
  assign pos_bad  = (CMP_W'(pos_r) >= CMP_W'(count_r));

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = '0;
    raddr     = '0;
    stat      = ST_OK;
    unique case (cmd_r)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (full) begin
          stat = ST_FULL;
        end else if (empty) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          we        = 1'b1;
          count_nxt = CNT_W'(1);
        end else if (cmd_r == CMD_PUSH_BACK) begin
          tail_nxt  = tail_inc;
          waddr     = tail_inc;
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          head_nxt  = head_dec;
          waddr     = head_dec;
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) begin
          stat = ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = (cmd_r == CMD_POP_FRONT) ? head_r : tail_r;
          if (count_r == CNT_W'(1)) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = '0;
          end else if (cmd_r == CMD_POP_FRONT) begin
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
          end else begin
            tail_nxt  = tail_dec;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      CMD_READ_POS: begin
        if (pos_bad) begin
          stat = ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = pos_wrap[IDX_W-1:0];
        end
      end
      CMD_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      rd_ok_r <= 1'b0;
    end else if (ctl.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      rd_ok_r <= re;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      val_r <= DATA_WIDTH'(in_value);
      pos_r <= in_position;
    end
    if (ctl.exec) begin
      status_r <= stat;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  // element store: at most one write or one registered read per command
  always_ff @(posedge clk) begin
    if (ctl.exec && we) begin
      mem[waddr] <= val_r;
    end
    if (ctl.exec && re) begin
      rd_q <= mem[raddr];
    end
  end

  assign out_data      = rd_ok_r ? DATA_W'(rd_q) : '0;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("element count beyond depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("empty queue with pointers away from zero");
  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && full && (cmd_r == CMD_PUSH_BACK || cmd_r == CMD_PUSH_FRONT))
    |=> (count_r == CNT_FULL && status_r == ST_FULL && $stable(head_r)))
    else $error("push into full queue changed state");
  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> (occ_r == OCC_W'(count_r)))
    else $error("reported occupancy differs from count");
`endif

endmodule
